// File: sv/tdq_pkg.sv
// Package for the thread deque: operation codes and transaction payload types.
// No dependencies; used by thread_deque_linked_table.
package tdq_pkg;

	localparam int TID_W = 6;
	localparam int CNT_W = 7;

	typedef enum logic [2:0] {
		MODE_PUSH_FRONT = 3'd0,
		MODE_PUSH_BACK  = 3'd1,
		MODE_POP_FRONT  = 3'd2,
		MODE_POP_BACK   = 3'd3,
		MODE_REMOVE     = 3'd4,
		MODE_ROTATE     = 3'd5,
		MODE_CLEAR      = 3'd6,
		MODE_CONTAINS   = 3'd7
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [TID_W-1:0]   thread_id;
	} op_t;

	typedef struct packed {
		logic [TID_W-1:0]   popped_thread;
		logic               popped_valid;
		logic               accepted;
		logic               is_member;
		logic [CNT_W-1:0]   count;
		logic [TID_W-1:0]   head_thread;
		logic [TID_W-1:0]   tail_thread;
	} res_t;

endpackage

// File: sv/tdq_link_mem.sv
// Next and prev link tables of the thread deque, one registered read port
// and one write port each. No package dependencies.
module tdq_link_mem #(
	parameter int SLOTS = 64
) (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [$clog2(SLOTS)-1:0]    rd_addr,
	input  logic                        next_we,
	input  logic [$clog2(SLOTS)-1:0]    next_addr,
	input  logic [$clog2(SLOTS)-1:0]    next_wdata,
	input  logic                        prev_we,
	input  logic [$clog2(SLOTS)-1:0]    prev_addr,
	input  logic [$clog2(SLOTS)-1:0]    prev_wdata,
	output logic [$clog2(SLOTS)-1:0]    next_rd,
	output logic [$clog2(SLOTS)-1:0]    prev_rd
);

	localparam int IW = $clog2(SLOTS);

	logic [IW-1:0] next_mem [SLOTS];
	logic [IW-1:0] prev_mem [SLOTS];
	logic [IW-1:0] next_rd_q;
	logic [IW-1:0] prev_rd_q;

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_addr] <= next_wdata;
		end
		if (rd_en) begin
			next_rd_q <= next_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_addr] <= prev_wdata;
		end
		if (rd_en) begin
			prev_rd_q <= prev_mem[rd_addr];
		end
	end

	assign next_rd = next_rd_q;
	assign prev_rd = prev_rd_q;

endmodule

// File: sv/thread_deque_linked_table.sv
// Thread ready queue kept as a doubly linked list over thread ids.
// The result is registered as the execute state completes. No new
// transaction is taken before the link table read at acceptance and the
// write-back of neighbor links in the execute state are done; a stalled
// result holds the execute state until the result is taken.
// Reset empties the list and clears all membership bits at once; the link
// tables are not initialized and need no clearing pass.
module thread_deque_linked_table #(
	parameter int NUM_THREADS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            op_valid,
	output logic            op_stall,
	input  tdq_pkg::op_t    op,
	output logic            res_valid,
	input  logic            res_stall,
	output tdq_pkg::res_t   res
);

	localparam int TW    = tdq_pkg::TID_W;
	localparam int OCW   = tdq_pkg::CNT_W;
	localparam int SLOTS = (NUM_THREADS < (1 << TW)) ? NUM_THREADS : (1 << TW);
	localparam int IW    = $clog2(SLOTS);
	localparam int CW    = $clog2(SLOTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t          state_q;
	tdq_pkg::mode_t  mode_s1;
	logic [TW-1:0]   id_s1;

	logic [IW-1:0]   head_q, tail_q;
	logic [CW-1:0]   cnt_q;
	logic [SLOTS-1:0] member_q;

	logic            res_valid_q;
	tdq_pkg::res_t   res_q;

	logic            accept, done;
	logic [IW-1:0]   rd_addr;
	logic [IW-1:0]   next_rd, prev_rd;

	logic            id_ok, mem_hit, cnt_nz, cnt_one, at_head, at_tail;
	logic [IW-1:0]   id_idx;
	logic [IW-1:0]   head_d, tail_d;
	logic [CW-1:0]   cnt_d;
	logic [SLOTS-1:0] member_d;
	logic            nwe, pwe;
	logic [IW-1:0]   naddr, ndata, paddr, pdata;
	logic [TW-1:0]   popped;
	logic            pvalid, acc;

	assign accept   = op_valid && !op_stall;
	assign op_stall = (state_q == ST_EXEC);
	assign done     = (state_q == ST_EXEC) && (!res_valid_q || !res_stall);

	// Pick the entry whose links the operation needs.
	always_comb begin
		case (op.mode) inside
			tdq_pkg::MODE_POP_BACK:                         rd_addr = tail_q;
			tdq_pkg::MODE_POP_FRONT, tdq_pkg::MODE_ROTATE:  rd_addr = head_q;
			default:                                        rd_addr = op.thread_id[IW-1:0];
		endcase
	end

	tdq_link_mem #(
		.SLOTS (SLOTS)
	) u_link_mem (
		.clk        (clk),
		.rd_en      (accept),
		.rd_addr    (rd_addr),
		.next_we    (nwe && done),
		.next_addr  (naddr),
		.next_wdata (ndata),
		.prev_we    (pwe && done),
		.prev_addr  (paddr),
		.prev_wdata (pdata),
		.next_rd    (next_rd),
		.prev_rd    (prev_rd)
	);

	assign id_idx  = id_s1[IW-1:0];
	assign id_ok   = int'(id_s1) < NUM_THREADS;
	assign mem_hit = id_ok && member_q[id_idx];
	assign cnt_nz  = (cnt_q != '0);
	assign cnt_one = (cnt_q == CW'(1));
	assign at_head = (id_idx == head_q);
	assign at_tail = (id_idx == tail_q);

	// Head's prev and tail's next are never read, so they are not kept.
	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		cnt_d    = cnt_q;
		member_d = member_q;
		nwe      = 1'b0;
		naddr    = id_idx;
		ndata    = head_q;
		pwe      = 1'b0;
		paddr    = id_idx;
		pdata    = tail_q;
		popped   = '0;
		pvalid   = 1'b0;
		acc      = 1'b0;
		unique case (mode_s1)
			tdq_pkg::MODE_PUSH_FRONT: begin
				if (id_ok && !mem_hit) begin
					acc              = 1'b1;
					member_d[id_idx] = 1'b1;
					cnt_d            = cnt_q + CW'(1);
					head_d           = id_idx;
					if (cnt_nz) begin
						nwe   = 1'b1;
						naddr = id_idx;
						ndata = head_q;
						pwe   = 1'b1;
						paddr = head_q;
						pdata = id_idx;
					end else begin
						tail_d = id_idx;
					end
				end
			end
			tdq_pkg::MODE_PUSH_BACK: begin
				if (id_ok && !mem_hit) begin
					acc              = 1'b1;
					member_d[id_idx] = 1'b1;
					cnt_d            = cnt_q + CW'(1);
					tail_d           = id_idx;
					if (cnt_nz) begin
						pwe   = 1'b1;
						paddr = id_idx;
						pdata = tail_q;
						nwe   = 1'b1;
						naddr = tail_q;
						ndata = id_idx;
					end else begin
						head_d = id_idx;
					end
				end
			end
			tdq_pkg::MODE_POP_FRONT: begin
				if (cnt_nz) begin
					acc              = 1'b1;
					pvalid           = 1'b1;
					popped           = TW'(head_q);
					member_d[head_q] = 1'b0;
					cnt_d            = cnt_q - CW'(1);
					head_d           = next_rd;
				end
			end
			tdq_pkg::MODE_POP_BACK: begin
				if (cnt_nz) begin
					acc              = 1'b1;
					pvalid           = 1'b1;
					popped           = TW'(tail_q);
					member_d[tail_q] = 1'b0;
					cnt_d            = cnt_q - CW'(1);
					tail_d           = prev_rd;
				end
			end
			tdq_pkg::MODE_REMOVE: begin
				if (mem_hit) begin
					acc              = 1'b1;
					member_d[id_idx] = 1'b0;
					cnt_d            = cnt_q - CW'(1);
					if (!at_head && !at_tail) begin
						nwe   = 1'b1;
						naddr = prev_rd;
						ndata = next_rd;
						pwe   = 1'b1;
						paddr = next_rd;
						pdata = prev_rd;
					end
					if (at_head) begin
						head_d = next_rd;
					end
					if (at_tail) begin
						tail_d = prev_rd;
					end
				end
			end
			tdq_pkg::MODE_ROTATE: begin
				if (cnt_nz) begin
					acc    = 1'b1;
					pvalid = 1'b1;
					popped = TW'(head_q);
					// Single thread: order stays as it is.
					if (!cnt_one) begin
						pwe    = 1'b1;
						paddr  = head_q;
						pdata  = tail_q;
						nwe    = 1'b1;
						naddr  = tail_q;
						ndata  = head_q;
						head_d = next_rd;
						tail_d = head_q;
					end
				end
			end
			tdq_pkg::MODE_CLEAR: begin
				acc      = cnt_nz;
				member_d = '0;
				cnt_d    = '0;
			end
			tdq_pkg::MODE_CONTAINS: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			cnt_q    <= '0;
			member_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (done) begin
						state_q  <= ST_IDLE;
						head_q   <= head_d;
						tail_q   <= tail_d;
						cnt_q    <= cnt_d;
						member_q <= member_d;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_s1 <= tdq_pkg::MODE_CONTAINS;
			id_s1   <= '0;
		end else if (accept) begin
			mode_s1 <= op.mode;
			id_s1   <= op.thread_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (done) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q.popped_thread <= popped;
			res_q.popped_valid  <= pvalid;
			res_q.accepted      <= acc;
			res_q.is_member     <= id_ok && member_d[id_idx];
			res_q.count         <= OCW'(cnt_d);
			res_q.head_thread   <= (cnt_d != '0) ? TW'(head_d) : '0;
			res_q.tail_thread   <= (cnt_d != '0) ? TW'(tail_d) : '0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_cnt_matches_bits: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) == $countones(member_q))
		else $error("list count disagrees with membership bits");

	a_ends_listed: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 |-> member_q[head_q] && member_q[tail_q])
		else $error("head or tail thread not listed");

	a_single_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CW'(1) |-> head_q == tail_q)
		else $error("one-thread list with distinct head and tail");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_EXEC)
		else $error("accepted transaction not executed");

	a_result_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_EXEC))
		else $error("result raised without execution");

endmodule

// File: test/tb_top.sv
// Testbench for thread_deque_linked_table: directed and random deque operations are
// checked field by field against a linked-list predictor kept inside the bench.
// Depends on tdq_pkg for the operation codes and the transaction payload types.
module tb_top;

	localparam int NTHR = 64;
	localparam logic [6:0] NO_LINK = 7'd64;
	localparam int IDLE_PCT = 26;
	localparam int QUIET_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic op_valid;
	logic op_stall;
	tdq_pkg::op_t op;
	logic res_valid;
	logic res_stall;
	tdq_pkg::res_t res;

	// Predicted deque state.
	logic [6:0] next_of [NTHR];
	logic [6:0] prev_of [NTHR];
	bit listed [NTHR];
	logic [6:0] head_id;
	logic [6:0] tail_id;
	logic [6:0] n_listed;

	tdq_pkg::res_t expected_results [$];
	int fail_count;
	int quiet_cycles;
	bit send_gaps;
	bit recv_gaps;

	thread_deque_linked_table u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.op_valid(op_valid),
		.op_stall(op_stall),
		.op(op),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic append_tail(input logic [5:0] t);
		next_of[t] = NO_LINK;
		prev_of[t] = tail_id;
		if (tail_id != NO_LINK) begin
			next_of[tail_id[5:0]] = {1'b0, t};
		end else begin
			head_id = {1'b0, t};
		end
		tail_id = {1'b0, t};
		listed[t] = 1'b1;
		n_listed++;
	endtask

	task automatic detach(input logic [5:0] t);
		logic [6:0] p;
		logic [6:0] n;
		p = prev_of[t];
		n = next_of[t];
		if (p != NO_LINK) begin
			next_of[p[5:0]] = n;
		end else begin
			head_id = n;
		end
		if (n != NO_LINK) begin
			prev_of[n[5:0]] = p;
		end else begin
			tail_id = p;
		end
		listed[t] = 1'b0;
		if (n_listed != 0) n_listed--;
	endtask

	// Apply one operation to the predicted deque and queue the result it must give.
	task automatic predict_deque_op(input tdq_pkg::op_t o);
		tdq_pkg::res_t r;
		logic [6:0] t;
		logic [5:0] id;
		r = '0;
		id = o.thread_id;
		case (o.mode) inside
			tdq_pkg::MODE_PUSH_FRONT, tdq_pkg::MODE_PUSH_BACK: begin
				if (!listed[id]) begin
					if (o.mode == tdq_pkg::MODE_PUSH_BACK) begin
						append_tail(id);
					end else begin
						prev_of[id] = NO_LINK;
						next_of[id] = head_id;
						if (head_id != NO_LINK) begin
							prev_of[head_id[5:0]] = {1'b0, id};
						end else begin
							tail_id = {1'b0, id};
						end
						head_id = {1'b0, id};
						listed[id] = 1'b1;
						n_listed++;
					end
					r.accepted = 1'b1;
				end
			end
			tdq_pkg::MODE_POP_FRONT, tdq_pkg::MODE_POP_BACK, tdq_pkg::MODE_ROTATE: begin
				t = (o.mode == tdq_pkg::MODE_POP_BACK) ? tail_id : head_id;
				if (n_listed != 0 && !t[6] && listed[t[5:0]]) begin
					detach(t[5:0]);
					if (o.mode == tdq_pkg::MODE_ROTATE) append_tail(t[5:0]);
					r.popped_thread = t[5:0];
					r.popped_valid = 1'b1;
					r.accepted = 1'b1;
				end
			end
			tdq_pkg::MODE_REMOVE: begin
				if (listed[id]) begin
					detach(id);
					r.accepted = 1'b1;
				end
			end
			tdq_pkg::MODE_CLEAR: begin
				r.accepted = (n_listed != 0);
				listed = '{default: 1'b0};
				head_id = NO_LINK;
				tail_id = NO_LINK;
				n_listed = '0;
			end
			default: ;
		endcase
		r.is_member = listed[id];
		r.count = n_listed;
		r.head_thread = (n_listed != 0) ? head_id[5:0] : '0;
		r.tail_thread = (n_listed != 0) ? tail_id[5:0] : '0;
		expected_results.push_back(r);
	endtask

	// Offer one transaction, hold it until taken, then predict its result.
	task automatic send_op(input tdq_pkg::mode_t m, input logic [5:0] tid);
		while (send_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
			op_valid <= 1'b0;
			@(posedge clk);
		end
		op_valid <= 1'b1;
		op <= tdq_pkg::op_t'{mode: m, thread_id: tid};
		@(posedge clk);
		while (op_stall) @(posedge clk);
		predict_deque_op(tdq_pkg::op_t'{mode: m, thread_id: tid});
	endtask

	// Pushes outweigh pops and removals, and removals mostly pick listed threads, so the list grows deep.
	task automatic send_random_op();
		int r;
		tdq_pkg::mode_t m;
		logic [5:0] id;
		r = $urandom_range(0, 99);
		id = 6'($urandom_range(0, NTHR - 1));
		if (r < 18) m = tdq_pkg::MODE_PUSH_BACK;
		else if (r < 34) m = tdq_pkg::MODE_PUSH_FRONT;
		else if (r < 44) m = tdq_pkg::MODE_POP_FRONT;
		else if (r < 52) m = tdq_pkg::MODE_POP_BACK;
		else if (r < 64) m = tdq_pkg::MODE_REMOVE;
		else if (r < 74) m = tdq_pkg::MODE_ROTATE;
		else if (r < 77) m = tdq_pkg::MODE_CLEAR;
		else m = tdq_pkg::MODE_CONTAINS;
		if (m == tdq_pkg::MODE_REMOVE && $urandom_range(0, 3) != 0) begin
			for (int k = 0; k < 8 && !listed[id]; k++) id = 6'($urandom_range(0, NTHR - 1));
		end
		send_op(m, id);
	endtask

	task automatic test_edge_cases();
		send_op(tdq_pkg::MODE_CONTAINS, 6'd0);
		send_op(tdq_pkg::MODE_POP_FRONT, 6'd5);
		send_op(tdq_pkg::MODE_POP_BACK, 6'd5);
		send_op(tdq_pkg::MODE_ROTATE, 6'd5);
		send_op(tdq_pkg::MODE_CLEAR, 6'd0);
		send_op(tdq_pkg::MODE_REMOVE, 6'd63);
		send_op(tdq_pkg::MODE_PUSH_BACK, 6'd0);
		send_op(tdq_pkg::MODE_PUSH_BACK, 6'd63);
		send_op(tdq_pkg::MODE_PUSH_FRONT, 6'd42);
		send_op(tdq_pkg::MODE_PUSH_BACK, 6'd63);
		send_op(tdq_pkg::MODE_PUSH_FRONT, 6'd0);
		send_op(tdq_pkg::MODE_ROTATE, 6'd21);
		send_op(tdq_pkg::MODE_CONTAINS, 6'd63);
		send_op(tdq_pkg::MODE_CONTAINS, 6'd21);
		// remove from the middle of the list
		send_op(tdq_pkg::MODE_REMOVE, 6'd63);
		send_op(tdq_pkg::MODE_POP_BACK, 6'd0);
		send_op(tdq_pkg::MODE_ROTATE, 6'd0);
		send_op(tdq_pkg::MODE_POP_FRONT, 6'd0);
		send_op(tdq_pkg::MODE_PUSH_FRONT, 6'd21);
		send_op(tdq_pkg::MODE_PUSH_BACK, 6'd42);
		send_op(tdq_pkg::MODE_REMOVE, 6'd21);
		send_op(tdq_pkg::MODE_REMOVE, 6'd42);
		send_op(tdq_pkg::MODE_PUSH_BACK, 6'd21);
		send_op(tdq_pkg::MODE_CLEAR, 6'd63);
		send_op(tdq_pkg::MODE_CONTAINS, 6'd21);
	endtask

	// Fill the list to all threads in shuffled order, then drain it.
	task automatic test_fill_and_drain();
		logic [5:0] order [NTHR];
		logic [5:0] tmp;
		int j;
		for (int i = 0; i < NTHR; i++) order[i] = 6'(i);
		for (int i = NTHR - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < NTHR; i++) begin
			send_op($urandom_range(0, 1) ? tdq_pkg::MODE_PUSH_BACK : tdq_pkg::MODE_PUSH_FRONT,
				order[i]);
		end
		repeat (6) send_op(tdq_pkg::MODE_PUSH_FRONT, 6'($urandom_range(0, NTHR - 1)));
		repeat (4) send_op(tdq_pkg::MODE_CONTAINS, 6'($urandom_range(0, NTHR - 1)));
		repeat (10) send_op(tdq_pkg::MODE_ROTATE, 6'($urandom_range(0, NTHR - 1)));
		repeat (NTHR + 1) begin
			send_op($urandom_range(0, 1) ? tdq_pkg::MODE_POP_BACK : tdq_pkg::MODE_POP_FRONT,
				6'($urandom_range(0, NTHR - 1)));
		end
	endtask

	task automatic test_drain_pause();
		repeat (12) send_random_op();
		op_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (12) send_random_op();
	endtask

	task automatic test_random_ops(input int n_ops);
		for (int i = 0; i < n_ops; i++) begin
			// long run with both sides busy every cycle
			send_gaps = !(i >= 80 && i < 200);
			recv_gaps = send_gaps;
			send_random_op();
		end
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
	endtask

	always @(posedge clk) begin
		res_stall <= recv_gaps && ($urandom_range(0, 99) < IDLE_PCT);
	end

	task automatic compare_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		tdq_pkg::res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing expected: expected none, actual %p",
					$time, res);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				compare_field("popped_thread", 8'(want.popped_thread),
					8'(res.popped_thread));
				compare_field("popped_valid", 8'(want.popped_valid), 8'(res.popped_valid));
				compare_field("accepted", 8'(want.accepted), 8'(res.accepted));
				compare_field("is_member", 8'(want.is_member), 8'(res.is_member));
				compare_field("count", 8'(want.count), 8'(res.count));
				compare_field("head_thread", 8'(want.head_thread), 8'(res.head_thread));
				compare_field("tail_thread", 8'(want.tail_thread), 8'(res.tail_thread));
			end
		end
	end

	// Abort when no transaction moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (op_valid && !op_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		op_valid = 1'b0;
		op = '0;
		res_stall = 1'b0;
		quiet_cycles = 0;
		fail_count = 0;
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		head_id = NO_LINK;
		tail_id = NO_LINK;
		n_listed = '0;
		listed = '{default: 1'b0};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edge_cases();
		test_fill_and_drain();
		test_drain_pause();
		test_random_ops(320);

		op_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: filelist.f
sv/tdq_pkg.sv
sv/tdq_link_mem.sv
sv/thread_deque_linked_table.sv
test/tb_top.sv
